// ===== hw/rtl/pats_pkg.sv =====
`default_nettype none

package pats_pkg;

    // Default sizes.
    localparam int DEF_NUM_PRIORITIES = 140;
    localparam int DEF_NUM_TASKS      = 64;

    // Opcodes of the command channel.
    typedef logic [2:0] opcode_t;
    localparam opcode_t OP_FORK  = 3'd0;
    localparam opcode_t OP_WAKE  = 3'd1;
    localparam opcode_t OP_BLOCK = 3'd2;
    localparam opcode_t OP_TICK  = 3'd3;
    localparam opcode_t OP_SCHED = 3'd4;
    localparam opcode_t OP_SETP  = 3'd5;

    // Configuration register indexes.
    typedef logic [2:0] cfg_idx_t;
    localparam cfg_idx_t CFG_RT_LIMIT    = 3'd0;
    localparam cfg_idx_t CFG_LONG_LIMIT  = 3'd1;
    localparam cfg_idx_t CFG_LONG_SCALE  = 3'd2;
    localparam cfg_idx_t CFG_SHORT_SCALE = 3'd3;

    // Configuration reset values.
    localparam logic [7:0] RST_RT_LIMIT    = 8'd100;
    localparam logic [7:0] RST_LONG_LIMIT  = 8'd120;
    localparam logic [7:0] RST_LONG_SCALE  = 8'd20;
    localparam logic [7:0] RST_SHORT_SCALE = 8'd5;

    // Queue counts and array totals saturate here.
    localparam logic [6:0] CNT_MAX = 7'd127;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_WAKE_WR,
        ST_SETP_WR,
        ST_TICK_T,
        ST_BLK_T,
        ST_POP_QRD,
        ST_POP_Q,
        ST_POP_L,
        ST_TPUSH_T,
        ST_PUSH_QRD,
        ST_PUSH_Q,
        ST_PUSH_LWR,
        ST_SCHED_WAIT,
        ST_SCHED_Q,
        ST_FIN
    } state_t;

    // Update of one bit of the ready map.
    typedef struct packed {
        logic       we;
        logic       arr;
        logic [7:0] prio;
        logic       val;
    } map_upd_t;

    // Start of a search for the most urgent non-empty queue.
    typedef struct packed {
        logic start;
        logic arr;
    } search_req_t;

    typedef struct packed {
        logic       done;
        logic       found;
        logic [7:0] prio;
    } search_rsp_t;

    function automatic logic [6:0] sat_inc(input logic [6:0] v);
        return (v < CNT_MAX) ? v + 7'd1 : v;
    endfunction

    function automatic logic [6:0] sat_dec(input logic [6:0] v);
        return (v != 7'd0) ? v - 7'd1 : v;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/pats_ready_map.sv =====
`default_nettype none

// Non-empty bit of every queue in both arrays, with a search that looks at
// eight priorities per cycle, most urgent group first.
module pats_ready_map #(
    parameter int NUM_PRIORITIES = pats_pkg::DEF_NUM_PRIORITIES
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire pats_pkg::map_upd_t    upd,
    input  wire                        q_arr,
    input  wire  [7:0]                 q_prio,
    output logic                       q_ne,
    input  wire pats_pkg::search_req_t req,
    output pats_pkg::search_rsp_t      rsp
);

    localparam int NG_RAW = (NUM_PRIORITIES + 7) / 8;
    localparam int NG     = (NG_RAW < 2) ? 2 : NG_RAW;
    localparam int GW     = $clog2(NG);
    localparam int NB     = NG * 8;
    localparam int BW     = GW + 3;

    logic [1:0][NB-1:0] map_reg;
    logic               busy_reg, busy_next;
    logic               arr_reg, arr_next;
    logic [GW-1:0]      grp_reg, grp_next;
    logic [7:0]         bits;
    logic [2:0]         low;

    assign q_ne = map_reg[q_arr][BW'(q_prio)];
    assign bits = map_reg[arr_reg][{grp_reg, 3'b000} +: 8];

    always_comb
    begin
        low = 3'd0;
        for (int i = 7; i >= 0; i--)
        begin
            if (bits[i])
            begin
                low = 3'(i);
            end
        end
    end

    always_comb
    begin
        rsp.found = |bits;
        rsp.done  = busy_reg && ((|bits) || (grp_reg == GW'(NG - 1)));
        rsp.prio  = 8'({grp_reg, low});
    end

    always_comb
    begin
        busy_next = busy_reg;
        arr_next  = arr_reg;
        grp_next  = grp_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            arr_next  = req.arr;
            grp_next  = '0;
        end
        else if (rsp.done)
        begin
            busy_next = 1'b0;
        end
        else if (busy_reg)
        begin
            grp_next = grp_reg + GW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_reg  <= '0;
            busy_reg <= 1'b0;
            arr_reg  <= 1'b0;
            grp_reg  <= '0;
        end
        else
        begin
            if (upd.we)
            begin
                map_reg[upd.arr][BW'(upd.prio)] <= upd.val;
            end
            busy_reg <= busy_next;
            arr_reg  <= arr_next;
            grp_reg  <= grp_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/priority_array_task_scheduler_unit.sv =====
`default_nettype none

// Channel   | Direction | Handshake              | Beat contents
// ----------+-----------+------------------------+------------------------------------------
// command   | in        | in_valid / in_ready    | opcode, task_id, priority_req, slice_ticks
// result    | out       | out_valid / out_ready  | current_task, switched, resched_needed,
//           |           |                        | went_idle, fault
// config    | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One command beat is worked on at a time by a sequencer around two memories with
// a registered read port: the task table and the queue table. Set priority only
// rewrites a task entry. Fork and wake push the task onto a queue of the active
// array; block pops the head of the running task's queue. A tick counts down the
// slice; when it expires the head of that queue is popped and the task is pushed
// onto the other array. Schedule scans the ready map in groups of eight priorities
// (up to 18 groups for 140) and reads the queue when a queued task is found.
// After reset the tables read as zero at once: the task table keeps a valid bit
// per entry and a queue entry counts only when its ready-map bit is set.
// A result that is not taken holds the sequencer in its last step; the next command
// beat is taken as soon as that result has moved into the output register.
module priority_array_task_scheduler_unit #(
    parameter int NUM_PRIORITIES = pats_pkg::DEF_NUM_PRIORITIES,
    parameter int NUM_TASKS      = pats_pkg::DEF_NUM_TASKS
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_ready,
    input  wire  [2:0]  opcode,
    input  wire  [5:0]  task_id,
    input  wire  [7:0]  priority_req,
    input  wire  [15:0] slice_ticks,
    output logic        out_valid,
    input  wire         out_ready,
    output logic [5:0]  current_task,
    output logic        switched,
    output logic        resched_needed,
    output logic        went_idle,
    output logic        fault,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [2:0]  cfg_index,
    input  wire  [7:0]  cfg_data
);

    localparam int PW = $clog2(NUM_PRIORITIES);
    localparam int TW = $clog2(NUM_TASKS);
    localparam int NQ = 2 * NUM_PRIORITIES;
    localparam int QW = $clog2(NQ);
    localparam int DW = $clog2(NUM_PRIORITIES + 1);

    typedef struct packed {
        logic [PW-1:0] prio;
        logic [15:0]   slice;
        logic [TW-1:0] link;
    } tent_t;

    typedef struct packed {
        logic [TW-1:0] head;
        logic [TW-1:0] tail;
        logic [6:0]    count;
    } qent_t;

    // Task table memory and its valid bits.
    tent_t               task_mem [NUM_TASKS];
    logic [NUM_TASKS-1:0] task_vld_reg;
    tent_t               t_rdata_reg;
    logic                t_rvld_reg;
    logic                t_re, t_we;
    logic [TW-1:0]       t_raddr, t_waddr;
    tent_t               t_wdata;
    tent_t               tdata;

    // Queue table memory.
    qent_t         queue_mem [NQ];
    qent_t         q_rdata_reg;
    logic          q_re, q_we;
    logic [QW-1:0] q_raddr, q_waddr;
    qent_t         q_wdata;

    // Sequencer state.
    pats_pkg::state_t  state_reg, state_next;
    pats_pkg::opcode_t op_reg;
    logic [TW-1:0]     tid_reg;
    logic              tid_ok_reg;
    logic [PW-1:0]     preq_reg;
    logic [15:0]       sl_reg;
    logic [TW-1:0]     subj_reg, subj_next;
    logic [PW-1:0]     pr_reg, pr_next;
    logic              parr_reg, parr_next;
    logic [TW-1:0]     tail_reg, tail_next;
    logic              act_reg, act_next;
    logic [TW-1:0]     run_reg, run_next;
    logic              resched_reg, resched_next;
    logic [1:0][6:0]   cnt_reg, cnt_next;
    logic              fault_reg, fault_next;
    logic              sw_reg, sw_next;
    logic              idle_reg, idle_next;

    logic [7:0] rt_limit_reg, long_limit_reg, long_scale_reg, short_scale_reg;

    logic       out_valid_reg;
    logic [5:0] out_task_reg;
    logic       out_sw_reg, out_resched_reg, out_idle_reg, out_fault_reg;

    logic in_acc, out_load;

    // Ready map and search.
    pats_pkg::map_upd_t    map_upd;
    pats_pkg::search_req_t srch_req;
    pats_pkg::search_rsp_t srch_rsp;
    logic                  q_ne;

    // Input decode.
    logic [8:0]    tid_wide;
    logic          tid_ok_in;
    logic [PW-1:0] preq_in;

    // Work signals.
    logic [QW-1:0]    qi, qi_srch;
    logic             rt_task, expire;
    logic [15:0]      s_dec, slice_new;
    logic [DW-1:0]    lvl_dist;
    logic [7:0]       scale;
    logic [DW+7:0]    prod;
    logic [6:0]       new_cnt;
    logic [TW-1:0]    sched_pick;

    pats_ready_map #(
        .NUM_PRIORITIES(NUM_PRIORITIES)
    ) u_map (
        .clk   (clk),
        .rst_n (rst_n),
        .upd   (map_upd),
        .q_arr (parr_reg),
        .q_prio(8'(pr_reg)),
        .q_ne  (q_ne),
        .req   (srch_req),
        .rsp   (srch_rsp)
    );

    assign in_ready  = (state_reg == pats_pkg::ST_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign out_load  = (state_reg == pats_pkg::ST_FIN) && (!out_valid_reg || out_ready);
    assign cfg_ready = 1'b1;

    assign tid_wide  = 9'(task_id);
    assign tid_ok_in = tid_wide < 9'(NUM_TASKS);
    assign preq_in   = ({1'b0, priority_req} >= 9'(NUM_PRIORITIES)) ?
                       PW'(NUM_PRIORITIES - 1) : PW'(priority_req);

    // A task entry that was never written reads as zero.
    assign tdata = t_rvld_reg ? t_rdata_reg : '0;

    assign qi      = parr_reg ? QW'(NUM_PRIORITIES) + QW'(pr_reg) : QW'(pr_reg);
    assign qi_srch = act_reg ? QW'(NUM_PRIORITIES) + QW'(srch_rsp.prio)
                             : QW'(srch_rsp.prio);

    // Slice bookkeeping for a tick on the running task.
    always_comb
    begin
        rt_task   = 8'(tdata.prio) < rt_limit_reg;
        s_dec     = tdata.slice - 16'd1;
        expire    = rt_task ? (tdata.slice <= 16'd1) : (s_dec == 16'd0);
        lvl_dist  = DW'(NUM_PRIORITIES) - DW'(tdata.prio);
        scale     = (8'(tdata.prio) < long_limit_reg) ? long_scale_reg : short_scale_reg;
        prod      = lvl_dist * scale;
        slice_new = 16'(prod);
    end

    assign new_cnt    = pats_pkg::sat_dec(q_rdata_reg.count);
    assign sched_pick = q_rdata_reg.head;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pats_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = pats_pkg::ST_DISPATCH;
                end
            end
            pats_pkg::ST_DISPATCH:
            begin
                case (op_reg)
                    pats_pkg::OP_FORK:
                        state_next = tid_ok_reg ? pats_pkg::ST_PUSH_QRD : pats_pkg::ST_FIN;
                    pats_pkg::OP_WAKE:
                        state_next = tid_ok_reg ? pats_pkg::ST_WAKE_WR : pats_pkg::ST_FIN;
                    pats_pkg::OP_BLOCK:
                        state_next = pats_pkg::ST_BLK_T;
                    pats_pkg::OP_TICK:
                        state_next = pats_pkg::ST_TICK_T;
                    pats_pkg::OP_SCHED:
                        state_next = pats_pkg::ST_SCHED_WAIT;
                    pats_pkg::OP_SETP:
                        state_next = tid_ok_reg ? pats_pkg::ST_SETP_WR : pats_pkg::ST_FIN;
                    default:
                        state_next = pats_pkg::ST_FIN;
                endcase
            end
            pats_pkg::ST_WAKE_WR:
                state_next = pats_pkg::ST_PUSH_QRD;
            pats_pkg::ST_SETP_WR:
                state_next = pats_pkg::ST_FIN;
            pats_pkg::ST_TICK_T:
                state_next = expire ? pats_pkg::ST_POP_QRD : pats_pkg::ST_FIN;
            pats_pkg::ST_BLK_T:
                state_next = pats_pkg::ST_POP_QRD;
            pats_pkg::ST_POP_QRD:
                state_next = q_ne ? pats_pkg::ST_POP_Q : pats_pkg::ST_FIN;
            pats_pkg::ST_POP_Q:
                state_next = pats_pkg::ST_POP_L;
            pats_pkg::ST_POP_L:
                state_next = (op_reg == pats_pkg::OP_TICK) ? pats_pkg::ST_TPUSH_T
                                                           : pats_pkg::ST_FIN;
            pats_pkg::ST_TPUSH_T:
                state_next = pats_pkg::ST_PUSH_QRD;
            pats_pkg::ST_PUSH_QRD:
                state_next = pats_pkg::ST_PUSH_Q;
            pats_pkg::ST_PUSH_Q:
                state_next = q_ne ? pats_pkg::ST_PUSH_LWR : pats_pkg::ST_FIN;
            pats_pkg::ST_PUSH_LWR:
                state_next = pats_pkg::ST_FIN;
            pats_pkg::ST_SCHED_WAIT:
            begin
                if (srch_rsp.done)
                begin
                    state_next = srch_rsp.found ? pats_pkg::ST_SCHED_Q : pats_pkg::ST_FIN;
                end
            end
            pats_pkg::ST_SCHED_Q:
                state_next = pats_pkg::ST_FIN;
            pats_pkg::ST_FIN:
            begin
                if (out_load)
                begin
                    state_next = pats_pkg::ST_IDLE;
                end
            end
            default:
                state_next = pats_pkg::ST_IDLE;
        endcase
    end

    // Datapath, memory ports and register updates per step.
    always_comb
    begin
        subj_next    = subj_reg;
        pr_next      = pr_reg;
        parr_next    = parr_reg;
        tail_next    = tail_reg;
        act_next     = act_reg;
        run_next     = run_reg;
        resched_next = resched_reg;
        cnt_next     = cnt_reg;
        fault_next   = fault_reg;
        sw_next      = sw_reg;
        idle_next    = idle_reg;
        t_re         = 1'b0;
        t_raddr      = '0;
        t_we         = 1'b0;
        t_waddr      = '0;
        t_wdata      = '0;
        q_re         = 1'b0;
        q_raddr      = '0;
        q_we         = 1'b0;
        q_waddr      = '0;
        q_wdata      = '0;
        map_upd      = '0;
        srch_req     = '0;

        case (state_reg)
            pats_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    fault_next = 1'b0;
                    sw_next    = 1'b0;
                    idle_next  = 1'b0;
                end
            end
            pats_pkg::ST_DISPATCH:
            begin
                case (op_reg)
                    pats_pkg::OP_FORK:
                    begin
                        if (tid_ok_reg)
                        begin
                            t_we         = 1'b1;
                            t_waddr      = tid_reg;
                            t_wdata      = '{prio: preq_reg, slice: sl_reg, link: '0};
                            subj_next    = tid_reg;
                            pr_next      = preq_reg;
                            parr_next    = act_reg;
                            resched_next = 1'b1;
                        end
                    end
                    pats_pkg::OP_WAKE, pats_pkg::OP_SETP:
                    begin
                        t_re      = tid_ok_reg;
                        t_raddr   = tid_reg;
                        subj_next = tid_reg;
                    end
                    pats_pkg::OP_BLOCK, pats_pkg::OP_TICK:
                    begin
                        t_re      = 1'b1;
                        t_raddr   = run_reg;
                        subj_next = run_reg;
                    end
                    pats_pkg::OP_SCHED:
                    begin
                        // The expired array becomes active once the active one is empty.
                        act_next      = (cnt_reg[act_reg] == 7'd0) ? ~act_reg : act_reg;
                        srch_req.start = 1'b1;
                        srch_req.arr   = act_next;
                    end
                    default:
                    begin
                        fault_next = 1'b1;
                    end
                endcase
            end
            pats_pkg::ST_WAKE_WR:
            begin
                t_we      = 1'b1;
                t_waddr   = subj_reg;
                t_wdata   = '{prio: tdata.prio, slice: tdata.slice, link: '0};
                pr_next   = tdata.prio;
                parr_next = act_reg;
            end
            pats_pkg::ST_SETP_WR:
            begin
                t_we    = 1'b1;
                t_waddr = subj_reg;
                t_wdata = '{prio: preq_reg, slice: tdata.slice, link: tdata.link};
            end
            pats_pkg::ST_TICK_T:
            begin
                t_we    = 1'b1;
                t_waddr = subj_reg;
                t_wdata = '{prio: tdata.prio, slice: expire ? slice_new : s_dec,
                            link: tdata.link};
                pr_next   = tdata.prio;
                parr_next = act_reg;
                if (expire)
                begin
                    resched_next = 1'b1;
                end
            end
            pats_pkg::ST_BLK_T:
            begin
                pr_next   = tdata.prio;
                parr_next = act_reg;
            end
            pats_pkg::ST_POP_QRD:
            begin
                if (q_ne)
                begin
                    q_re    = 1'b1;
                    q_raddr = qi;
                end
                else
                begin
                    fault_next = 1'b1;
                end
            end
            pats_pkg::ST_POP_Q:
            begin
                t_re    = 1'b1;
                t_raddr = q_rdata_reg.head;
            end
            pats_pkg::ST_POP_L:
            begin
                q_we    = 1'b1;
                q_waddr = qi;
                q_wdata = '{head: tdata.link, tail: q_rdata_reg.tail, count: new_cnt};
                if (new_cnt == 7'd0)
                begin
                    map_upd = '{we: 1'b1, arr: parr_reg, prio: 8'(pr_reg), val: 1'b0};
                end
                cnt_next[parr_reg] = pats_pkg::sat_dec(cnt_reg[parr_reg]);
                // An expired task goes on to the other array.
                if (op_reg == pats_pkg::OP_TICK)
                begin
                    t_re      = 1'b1;
                    t_raddr   = subj_reg;
                    parr_next = ~parr_reg;
                end
            end
            pats_pkg::ST_TPUSH_T:
            begin
                t_we    = 1'b1;
                t_waddr = subj_reg;
                t_wdata = '{prio: tdata.prio, slice: tdata.slice, link: '0};
            end
            pats_pkg::ST_PUSH_QRD:
            begin
                q_re    = 1'b1;
                q_raddr = qi;
            end
            pats_pkg::ST_PUSH_Q:
            begin
                q_we    = 1'b1;
                q_waddr = qi;
                q_wdata = '{head:  q_ne ? q_rdata_reg.head : subj_reg,
                            tail:  subj_reg,
                            count: q_ne ? pats_pkg::sat_inc(q_rdata_reg.count) : 7'd1};
                map_upd = '{we: 1'b1, arr: parr_reg, prio: 8'(pr_reg), val: 1'b1};
                cnt_next[parr_reg] = pats_pkg::sat_inc(cnt_reg[parr_reg]);
                if (q_ne)
                begin
                    t_re      = 1'b1;
                    t_raddr   = q_rdata_reg.tail;
                    tail_next = q_rdata_reg.tail;
                end
            end
            pats_pkg::ST_PUSH_LWR:
            begin
                t_we    = 1'b1;
                t_waddr = tail_reg;
                t_wdata = '{prio: tdata.prio, slice: tdata.slice, link: subj_reg};
            end
            pats_pkg::ST_SCHED_WAIT:
            begin
                if (srch_rsp.done)
                begin
                    if (srch_rsp.found)
                    begin
                        q_re    = 1'b1;
                        q_raddr = qi_srch;
                    end
                    else
                    begin
                        // Nothing queued: the idle task runs.
                        idle_next = 1'b1;
                        if (run_reg != '0)
                        begin
                            run_next     = '0;
                            resched_next = 1'b0;
                            sw_next      = 1'b1;
                        end
                    end
                end
            end
            pats_pkg::ST_SCHED_Q:
            begin
                if (sched_pick != run_reg)
                begin
                    run_next     = sched_pick;
                    resched_next = 1'b0;
                    sw_next      = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Task table: registered read, valid bit per entry.
    always_ff @(posedge clk)
    begin
        if (t_we)
        begin
            task_mem[t_waddr] <= t_wdata;
        end
        if (t_re)
        begin
            t_rdata_reg <= task_mem[t_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            task_vld_reg <= '0;
            t_rvld_reg   <= 1'b0;
        end
        else
        begin
            if (t_we)
            begin
                task_vld_reg[t_waddr] <= 1'b1;
            end
            if (t_re)
            begin
                t_rvld_reg <= task_vld_reg[t_raddr];
            end
        end
    end

    // Queue table: registered read. An entry is only used while its
    // ready-map bit is set, so it needs no clearing.
    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            queue_mem[q_waddr] <= q_wdata;
        end
        if (q_re)
        begin
            q_rdata_reg <= queue_mem[q_raddr];
        end
    end

    // Command beat capture.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            op_reg     <= opcode;
            tid_reg    <= TW'(tid_wide);
            tid_ok_reg <= tid_ok_in;
            preq_reg   <= preq_in;
            sl_reg     <= slice_ticks;
        end
        subj_reg <= subj_next;
        pr_reg   <= pr_next;
        parr_reg <= parr_next;
        tail_reg <= tail_next;
        fault_reg <= fault_next;
        sw_reg    <= sw_next;
        idle_reg  <= idle_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= pats_pkg::ST_IDLE;
            act_reg         <= 1'b0;
            run_reg         <= '0;
            resched_reg     <= 1'b0;
            cnt_reg         <= '0;
            rt_limit_reg    <= pats_pkg::RST_RT_LIMIT;
            long_limit_reg  <= pats_pkg::RST_LONG_LIMIT;
            long_scale_reg  <= pats_pkg::RST_LONG_SCALE;
            short_scale_reg <= pats_pkg::RST_SHORT_SCALE;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            act_reg     <= act_next;
            run_reg     <= run_next;
            resched_reg <= resched_next;
            cnt_reg     <= cnt_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    pats_pkg::CFG_RT_LIMIT:    rt_limit_reg    <= cfg_data;
                    pats_pkg::CFG_LONG_LIMIT:  long_limit_reg  <= cfg_data;
                    pats_pkg::CFG_LONG_SCALE:  long_scale_reg  <= cfg_data;
                    pats_pkg::CFG_SHORT_SCALE: short_scale_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_task_reg    <= 6'(run_reg);
            out_sw_reg      <= sw_reg;
            out_resched_reg <= resched_reg;
            out_idle_reg    <= idle_reg;
            out_fault_reg   <= fault_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign current_task   = out_task_reg;
    assign switched       = out_sw_reg;
    assign resched_needed = out_resched_reg;
    assign went_idle      = out_idle_reg;
    assign fault          = out_fault_reg;

    // The search unit only answers while the sequencer waits for it.
    a_search_in_sched: assert property (@(posedge clk) disable iff (!rst_n)
        srch_rsp.done |-> (state_reg == pats_pkg::ST_SCHED_WAIT))
        else $error("search answered outside a schedule");

    // A fault comes only from block, tick or an unknown opcode.
    a_fault_source: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && fault_reg) |->
            (op_reg == pats_pkg::OP_BLOCK || op_reg == pats_pkg::OP_TICK ||
             op_reg > pats_pkg::OP_SETP))
        else $error("fault raised by an opcode that cannot fault");

    // Going idle always leaves the idle task running.
    a_idle_task: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && idle_reg) |=> (current_task == 6'd0))
        else $error("went idle with a task other than the idle task");

    // The running task is always a task that exists.
    a_run_range: assert property (@(posedge clk) disable iff (!rst_n)
        (9'(run_reg) < 9'(NUM_TASKS)))
        else $error("running task out of range");

endmodule

`default_nettype wire

// ===== tb/priority_array_task_scheduler_unit_tb.sv =====
`default_nettype none

module priority_array_task_scheduler_unit_tb;

    localparam int NPRIO  = 140;
    localparam int NTASK  = 64;
    localparam int NQUEUE = 2 * NPRIO;

    // One command beat as the driver presents it.
    typedef struct packed {
        logic [2:0]  op;
        logic [5:0]  tid;
        logic [7:0]  prio;
        logic [15:0] slice;
    } cmd_t;

    // One result beat as the scheduler reports it.
    typedef struct packed {
        logic [5:0] task_no;
        logic       sw;
        logic       resched;
        logic       idle;
        logic       flt;
    } status_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  opcode;
    logic [5:0]  task_id;
    logic [7:0]  priority_req;
    logic [15:0] slice_ticks;
    logic        out_valid;
    logic        out_ready;
    logic [5:0]  current_task;
    logic        switched;
    logic        resched_needed;
    logic        went_idle;
    logic        fault;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [7:0]  cfg_data;

    priority_array_task_scheduler_unit i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .task_id        (task_id),
        .priority_req   (priority_req),
        .slice_ticks    (slice_ticks),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .current_task   (current_task),
        .switched       (switched),
        .resched_needed (resched_needed),
        .went_idle      (went_idle),
        .fault          (fault),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // Shadow copy of the scheduler state, updated once per accepted command beat.
    logic [7:0]  sh_rt_limit, sh_long_limit, sh_long_scale, sh_short_scale;
    logic [7:0]  sh_prio  [NTASK];
    logic [15:0] sh_slice [NTASK];
    logic [5:0]  sh_link  [NTASK];
    logic [5:0]  sh_head  [NQUEUE];
    logic [5:0]  sh_tail  [NQUEUE];
    logic [6:0]  sh_count [NQUEUE];
    logic        sh_busy  [NQUEUE];
    logic [6:0]  sh_total [2];
    logic        sh_act;
    logic [5:0]  sh_running;
    logic        sh_resched;

    cmd_t    pending_cmds[$];
    status_t expected_status[$];
    int      error_count;
    bit      quiet_phase;
    int      drv_gap;
    int      mon_gap;

    // Acceptance seen at the last rising edge, so the driver can move on.
    logic    in_ready_seen;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [15:0] reload_slice(input logic [7:0] p);
        logic [31:0] lvl_dist;
        logic [7:0]  scale;
        lvl_dist = NPRIO - p;
        scale    = (p < sh_long_limit) ? sh_long_scale : sh_short_scale;
        return 16'((lvl_dist * scale) & 32'hFFFF);
    endfunction

    function automatic logic [6:0] sat_inc_tb(input logic [6:0] v);
        return (v < 7'd127) ? v + 7'd1 : v;
    endfunction

    task automatic queue_append(input logic arr, input logic [5:0] t);
        int q;
        q = arr * NPRIO + sh_prio[t];
        sh_link[t] = '0;
        if (sh_busy[q])
            sh_link[sh_tail[q]] = t;
        else
            sh_head[q] = t;
        sh_tail[q] = t;
        sh_busy[q] = 1'b1;
        sh_count[q] = sat_inc_tb(sh_count[q]);
        sh_total[arr] = sat_inc_tb(sh_total[arr]);
    endtask

    // Returns 0 when the queue held nothing.
    function automatic bit queue_remove_head(input logic arr, input logic [7:0] p);
        int q;
        q = arr * NPRIO + p;
        if (!sh_busy[q])
            return 0;
        sh_head[q] = sh_link[sh_head[q]];
        if (sh_count[q] != 0)
            sh_count[q] = sh_count[q] - 7'd1;
        if (sh_count[q] == 0)
            sh_busy[q] = 1'b0;
        if (sh_total[arr] != 0)
            sh_total[arr] = sh_total[arr] - 7'd1;
        return 1;
    endfunction

    task automatic shadow_reset();
        sh_rt_limit    = pats_pkg::RST_RT_LIMIT;
        sh_long_limit  = pats_pkg::RST_LONG_LIMIT;
        sh_long_scale  = pats_pkg::RST_LONG_SCALE;
        sh_short_scale = pats_pkg::RST_SHORT_SCALE;
        for (int i = 0; i < NTASK; i++)
        begin
            sh_prio[i] = '0;
            sh_slice[i] = '0;
            sh_link[i] = '0;
        end
        for (int i = 0; i < NQUEUE; i++)
        begin
            sh_head[i] = '0;
            sh_tail[i] = '0;
            sh_count[i] = '0;
            sh_busy[i] = 1'b0;
        end
        sh_total[0] = '0;
        sh_total[1] = '0;
        sh_act = 1'b0;
        sh_running = '0;
        sh_resched = 1'b0;
    endtask

    // Work out the status beat that one command beat produces.
    task automatic predict_status(input cmd_t c);
        status_t     r;
        logic [7:0]  p;
        logic [7:0]  tp;
        logic [15:0] s;
        logic [5:0]  nxt;
        bit          expire;
        bit          found;
        r  = '0;
        p  = (c.prio >= NPRIO) ? 8'(NPRIO - 1) : c.prio;
        tp = sh_prio[sh_running];
        case (c.op)
            pats_pkg::OP_FORK:
            begin
                sh_prio[c.tid] = p;
                sh_slice[c.tid] = c.slice;
                queue_append(sh_act, c.tid);
                sh_resched = 1'b1;
            end
            pats_pkg::OP_WAKE:
                queue_append(sh_act, c.tid);
            pats_pkg::OP_BLOCK:
                r.flt = !queue_remove_head(sh_act, tp);
            pats_pkg::OP_TICK:
            begin
                s = sh_slice[sh_running];
                expire = (tp < sh_rt_limit) ? (s <= 16'd1) : (s == 16'd1);
                sh_slice[sh_running] = s - 16'd1;
                if (expire)
                begin
                    sh_slice[sh_running] = reload_slice(tp);
                    sh_resched = 1'b1;
                    if (queue_remove_head(sh_act, tp))
                        queue_append(!sh_act, sh_running);
                    else
                        r.flt = 1'b1;
                end
            end
            pats_pkg::OP_SCHED:
            begin
                nxt = '0;
                found = 0;
                if (sh_total[sh_act] == 0)
                    sh_act = !sh_act;
                for (int i = 0; i < NPRIO && !found; i++)
                begin
                    if (sh_busy[sh_act * NPRIO + i])
                    begin
                        nxt = sh_head[sh_act * NPRIO + i];
                        found = 1;
                    end
                end
                r.idle = !found;
                if (nxt != sh_running)
                begin
                    sh_running = nxt;
                    sh_resched = 1'b0;
                    r.sw = 1'b1;
                end
            end
            pats_pkg::OP_SETP:
                sh_prio[c.tid] = p;
            default:
                r.flt = 1'b1;
        endcase
        r.task_no = sh_running;
        r.resched = sh_resched;
        expected_status.push_back(r);
    endtask

    // Driver: presents queued command beats, changing inputs on the falling edge.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_ready_seen)
            begin
                if (drv_gap > 0)
                begin
                    drv_gap <= drv_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_cmds.size() > 0)
                begin
                    in_valid <= 1'b1;
                    {opcode, task_id, priority_req, slice_ticks} <= pending_cmds.pop_front();
                    if (!quiet_phase && $urandom_range(0, 5) == 0)
                        drv_gap <= $urandom_range(1, 5);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        in_ready_seen <= in_valid && in_ready;
        if (rst_n && in_valid && in_ready)
            predict_status({opcode, task_id, priority_req, slice_ticks});
    end

    // Monitor: takes status beats at the rising edge and compares each field.
    always @(posedge clk)
    begin
        status_t exp_s;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_status.size() == 0)
            begin
                $error("status beat with nothing expected");
                error_count++;
            end
            else
            begin
                exp_s = expected_status.pop_front();
                if (current_task !== exp_s.task_no)
                begin
                    $error("current_task expected %0d actual %0d", exp_s.task_no, current_task);
                    error_count++;
                end
                if (switched !== exp_s.sw)
                begin
                    $error("switched expected %0d actual %0d", exp_s.sw, switched);
                    error_count++;
                end
                if (resched_needed !== exp_s.resched)
                begin
                    $error("resched_needed expected %0d actual %0d", exp_s.resched,
                           resched_needed);
                    error_count++;
                end
                if (went_idle !== exp_s.idle)
                begin
                    $error("went_idle expected %0d actual %0d", exp_s.idle, went_idle);
                    error_count++;
                end
                if (fault !== exp_s.flt)
                begin
                    $error("fault expected %0d actual %0d", exp_s.flt, fault);
                    error_count++;
                end
            end
        end
    end

    // The receiver stalls in random bursts until the quiet phase.
    always @(negedge clk)
    begin
        if (mon_gap > 0)
        begin
            mon_gap <= mon_gap - 1;
            out_ready <= 1'b0;
        end
        else if (!quiet_phase && $urandom_range(0, 5) == 0)
        begin
            mon_gap <= $urandom_range(0, 4);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    function automatic cmd_t make_cmd(input logic [2:0] op, input logic [5:0] t,
                                      input logic [7:0] p, input logic [15:0] s);
        return {op, t, p, s};
    endfunction

    // Waits until every queued and expected beat is gone, plus a settling margin.
    task automatic drain();
        while (pending_cmds.size() > 0 || in_valid || expected_status.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(input pats_pkg::cfg_idx_t idx, input logic [7:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            pats_pkg::CFG_RT_LIMIT:    sh_rt_limit    = val;
            pats_pkg::CFG_LONG_LIMIT:  sh_long_limit  = val;
            pats_pkg::CFG_LONG_SCALE:  sh_long_scale  = val;
            pats_pkg::CFG_SHORT_SCALE: sh_short_scale = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // A random command beat, weighted toward a live mix of queued tasks and ticks.
    function automatic cmd_t random_cmd();
        int          k;
        logic [7:0]  p;
        logic [15:0] s;
        k = $urandom_range(0, 99);
        p = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 139));
        case ($urandom_range(0, 3))
            0: s = 16'($urandom);
            1: s = 16'($urandom_range(0, 3));
            default: s = 16'($urandom_range(0, 12));
        endcase
        if (k < 18)
            return make_cmd(pats_pkg::OP_FORK, 6'($urandom), p, s);
        else if (k < 28)
            return make_cmd(pats_pkg::OP_WAKE, 6'($urandom), p, s);
        else if (k < 38)
            return make_cmd(pats_pkg::OP_BLOCK, 6'($urandom), p, s);
        else if (k < 68)
            return make_cmd(pats_pkg::OP_TICK, 6'($urandom), p, s);
        else if (k < 90)
            return make_cmd(pats_pkg::OP_SCHED, 6'($urandom), p, s);
        else if (k < 97)
            return make_cmd(pats_pkg::OP_SETP, 6'($urandom), p, s);
        else
            return make_cmd(3'($urandom_range(6, 7)), 6'($urandom), p, s);
    endfunction

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        opcode = '0;
        task_id = '0;
        priority_req = '0;
        slice_ticks = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        error_count = 0;
        quiet_phase = 0;
        drv_gap = 0;
        mon_gap = 0;
        shadow_reset();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed beats: empty pops, idle schedule, field extremes, every opcode.
        pending_cmds.push_back(make_cmd(pats_pkg::OP_BLOCK, 6'd0, 8'd0, 16'd0));
        pending_cmds.push_back(make_cmd(pats_pkg::OP_SCHED, 6'd0, 8'd0, 16'd0));
        pending_cmds.push_back(make_cmd(pats_pkg::OP_TICK, 6'd0, 8'd0, 16'd0));
        pending_cmds.push_back(make_cmd(pats_pkg::OP_FORK, 6'd63, 8'd255, 16'hFFFF));
        pending_cmds.push_back(make_cmd(pats_pkg::OP_FORK, 6'd5, 8'd0, 16'd2));
        pending_cmds.push_back(make_cmd(pats_pkg::OP_FORK, 6'd6, 8'd0, 16'd1));
        pending_cmds.push_back(make_cmd(pats_pkg::OP_WAKE, 6'd5, 8'd0, 16'd0));
        pending_cmds.push_back(make_cmd(pats_pkg::OP_SCHED, 6'd0, 8'd0, 16'd0));
        pending_cmds.push_back(make_cmd(pats_pkg::OP_SCHED, 6'd0, 8'd0, 16'd0));
        pending_cmds.push_back(make_cmd(pats_pkg::OP_TICK, 6'd0, 8'd0, 16'd0));
        pending_cmds.push_back(make_cmd(pats_pkg::OP_TICK, 6'd0, 8'd0, 16'd0));
        pending_cmds.push_back(make_cmd(pats_pkg::OP_SCHED, 6'd0, 8'd0, 16'd0));
        pending_cmds.push_back(make_cmd(pats_pkg::OP_SETP, 6'd63, 8'd139, 16'd0));
        pending_cmds.push_back(make_cmd(pats_pkg::OP_SETP, 6'd6, 8'd140, 16'd0));
        pending_cmds.push_back(make_cmd(pats_pkg::OP_FORK, 6'd7, 8'd130, 16'd0));
        pending_cmds.push_back(make_cmd(pats_pkg::OP_BLOCK, 6'd0, 8'd0, 16'd0));
        pending_cmds.push_back(make_cmd(3'd6, 6'd0, 8'd0, 16'd0));
        pending_cmds.push_back(make_cmd(3'd7, 6'h2A, 8'hAA, 16'hAAAA));
        pending_cmds.push_back(make_cmd(pats_pkg::OP_SCHED, 6'd0, 8'd0, 16'd0));
        pending_cmds.push_back(make_cmd(pats_pkg::OP_TICK, 6'd0, 8'd0, 16'd0));
        pending_cmds.push_back(make_cmd(pats_pkg::OP_SCHED, 6'd0, 8'd0, 16'd0));
        drain();

        // Random phases, each under a different register setting.
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(pats_pkg::CFG_RT_LIMIT, 8'd0);
                    write_reg(pats_pkg::CFG_LONG_LIMIT, 8'd140);
                    write_reg(pats_pkg::CFG_LONG_SCALE, 8'd255);
                    write_reg(pats_pkg::CFG_SHORT_SCALE, 8'd0);
                end
                1:
                begin
                    write_reg(pats_pkg::CFG_RT_LIMIT, 8'd140);
                    write_reg(pats_pkg::CFG_LONG_LIMIT, 8'd0);
                    write_reg(pats_pkg::CFG_LONG_SCALE, 8'd0);
                    write_reg(pats_pkg::CFG_SHORT_SCALE, 8'd255);
                end
                5:
                begin
                    write_reg(pats_pkg::CFG_RT_LIMIT, pats_pkg::RST_RT_LIMIT);
                    write_reg(pats_pkg::CFG_LONG_LIMIT, pats_pkg::RST_LONG_LIMIT);
                    write_reg(pats_pkg::CFG_LONG_SCALE, pats_pkg::RST_LONG_SCALE);
                    write_reg(pats_pkg::CFG_SHORT_SCALE, pats_pkg::RST_SHORT_SCALE);
                end
                default:
                begin
                    write_reg(pats_pkg::CFG_RT_LIMIT, 8'($urandom_range(0, 140)));
                    write_reg(pats_pkg::CFG_LONG_LIMIT, 8'($urandom_range(0, 140)));
                    write_reg(pats_pkg::CFG_LONG_SCALE, 8'($urandom));
                    write_reg(pats_pkg::CFG_SHORT_SCALE, 8'($urandom));
                end
            endcase
            if (ph == 5)
                quiet_phase = 1;
            for (int n = 0; n < 140; n++)
                pending_cmds.push_back(random_cmd());
            drain();
        end

        if (error_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
